// ===== sv/srde_pkg.sv =====
// ----------------------------------------------------------------------------
// srde_pkg
// Shared types, constants and helpers of the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

	// field and register widths
	localparam int VALUE_W   = 32;
	localparam int SYM_W     = 8;
	localparam int RADIX_W   = 5;
	localparam int DIGREG_W  = 64;
	localparam int SYM_SLOTS = DIGREG_W / SYM_W;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;

	// default alphabet limit
	localparam int MAX_RADIX_DEF = 16;

	// longest digit string (base two of a 32-bit magnitude)
	localparam int TEXT_MAX  = VALUE_W;
	localparam int STACK_AW  = $clog2(TEXT_MAX);
	localparam int NDIG_W    = STACK_AW + 1;

	// division works through the dividend one byte per cycle
	localparam int CHUNK_W   = 8;
	localparam int CHUNKS    = VALUE_W / CHUNK_W;
	localparam int CHUNK_CW  = $clog2(CHUNKS);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// symbol codes
	localparam logic [SYM_W-1:0] SYM_MINUS   = 8'd45;
	localparam logic [SYM_W-1:0] SYM_PLUS    = 8'd43;
	localparam logic [SYM_W-1:0] SYM_LOWEST  = 8'd33;
	localparam logic [SYM_W-1:0] SYM_HIGHEST = 8'd126;

	// register indexes
	localparam logic [1:0] REG_RADIX       = 2'd0;
	localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
	localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

	// configuration register set
	typedef struct packed {
		logic [RADIX_W-1:0]  radix;
		logic [DIGREG_W-1:0] digits_low;
		logic [DIGREG_W-1:0] digits_high;
	} cfg_t;

	// one classified word waiting for conversion
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	// alphabet symbol for digit k
	function automatic logic [SYM_W-1:0] symbol_at(input cfg_t cfg, input logic [3:0] k);
		logic [DIGREG_W-1:0] w;
		begin
			w = k[3] ? cfg.digits_high : cfg.digits_low;
			symbol_at = w[{k[2:0], 3'b000} +: SYM_W];
		end
	endfunction

endpackage

// ===== sv/srde_regs.sv =====
// ----------------------------------------------------------------------------
// srde_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module srde_regs import srde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX:       cfg_q.radix       <= pwdata[RADIX_W-1:0];
				REG_DIGITS_LOW:  cfg_q.digits_low  <= pwdata;
				REG_DIGITS_HIGH: cfg_q.digits_high <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_RADIX:       prdata = PDATA_W'(cfg_q.radix);
			REG_DIGITS_LOW:  prdata = cfg_q.digits_low;
			REG_DIGITS_HIGH: prdata = cfg_q.digits_high;
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== sv/srde_front.sv =====
// ----------------------------------------------------------------------------
// srde_front
// Accepts input words, checks the alphabet and splits sign from magnitude.
// ----------------------------------------------------------------------------
module srde_front import srde_pkg::*; #(
	parameter int MAX_RADIX = MAX_RADIX_DEF
) (
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	input  cfg_t               cfg,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output item_t              push_item
);

	logic             alpha_ok;
	logic [SYM_W-1:0] syms [MAX_RADIX];
	logic             used [MAX_RADIX];

	// symbol slots in use
	always_comb begin
		for (int i = 0; i < MAX_RADIX; i++) begin
			syms[i] = symbol_at(cfg, 4'(i));
			used[i] = (RADIX_W'(i) < cfg.radix);
		end
	end

	// alphabet check: length, symbol range and no repeats
	always_comb begin
		alpha_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (used[i]) begin
				if (syms[i] < SYM_LOWEST || syms[i] > SYM_HIGHEST ||
				    syms[i] == SYM_PLUS || syms[i] == SYM_MINUS)
					alpha_ok = 1'b0;
				for (int j = i + 1; j < MAX_RADIX; j++) begin
					if (used[j] && syms[j] == syms[i])
						alpha_ok = 1'b0;
				end
			end
		end
	end

	// words under a bad alphabet are taken and dropped
	assign busy          = q_full;
	assign push          = start & ~q_full & alpha_ok;
	assign push_item.neg = value[VALUE_W-1];
	assign push_item.mag = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;

endmodule

// ===== sv/srde_queue.sv =====
// ----------------------------------------------------------------------------
// srde_queue
// Short first-in first-out queue of classified words.
// ----------------------------------------------------------------------------
module srde_queue import srde_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output item_t head
);

	item_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/srde_back.sv =====
// ----------------------------------------------------------------------------
// srde_back
// Divides the magnitude by the radix one digit at a time, stacks the
// remainders and plays them out most significant first.
// ----------------------------------------------------------------------------
module srde_back import srde_pkg::*; #(
	parameter int MAX_RADIX = MAX_RADIX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  item_t            head,
	output logic             pop,
	output logic             strobe,
	output logic [SYM_W-1:0] symbol,
	output logic             last
);

	localparam int DIGIT_W = $clog2(MAX_RADIX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   dividend_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [CHUNK_CW-1:0]  chunk_q;
	logic [NDIG_W-1:0]    ndig_q;
	logic [DIGIT_W-1:0]   stack_q [TEXT_MAX];

	logic [RADIX_W-1:0]   r;
	logic [RADIX_W:0]     t;
	logic [CHUNK_W-1:0]   qbits;
	logic [VALUE_W-1:0]   dividend_nx;
	logic                 chunk_end;
	logic [STACK_AW-1:0]  top_idx;
	logic [DIGIT_W-1:0]   top_digit;

	// one byte of restoring division per cycle
	always_comb begin
		r     = RADIX_W'(rem_q);
		qbits = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			t = {r, dividend_q[VALUE_W-1-i]};
			if (t >= {1'b0, cfg.radix}) begin
				t = t - {1'b0, cfg.radix};
				qbits[CHUNK_W-1-i] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		dividend_nx = {dividend_q[VALUE_W-CHUNK_W-1:0], qbits};
	end

	assign chunk_end = (chunk_q == CHUNK_CW'(CHUNKS - 1));
	assign top_idx   = ndig_q[STACK_AW-1:0] - 1'b1;
	assign top_digit = stack_q[top_idx];

	// result drive
	assign pop    = (state_q == ST_IDLE) & ~q_empty;
	assign strobe = (state_q == ST_EMIT);
	assign symbol = neg_q ? SYM_MINUS : symbol_at(cfg, 4'(top_digit));
	assign last   = ~neg_q & (ndig_q == NDIG_W'(1));

	// digit stack
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && chunk_end)
			stack_q[ndig_q[STACK_AW-1:0]] <= DIGIT_W'(r);
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dividend_q <= head.mag;
				rem_q      <= '0;
			end
			ST_DIV: begin
				dividend_q <= dividend_nx;
				rem_q      <= chunk_end ? '0 : DIGIT_W'(r);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			chunk_q <= '0;
			ndig_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						neg_q   <= head.neg;
						chunk_q <= '0;
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 1'b1;
					if (chunk_end) begin
						ndig_q <= ndig_q + 1'b1;
						if (dividend_nx == '0 || ndig_q == NDIG_W'(TEXT_MAX - 1))
							state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (neg_q) begin
						neg_q <= 1'b0;
					end else begin
						ndig_q <= ndig_q - 1'b1;
						if (ndig_q == NDIG_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/signed_radix_digit_emitter_top.sv =====
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top
// Writes a signed 32-bit word as text in a configurable digit alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   A word on value is taken at a clock edge where start is high and busy is
//   low. Each output character appears on symbol for one cycle with strobe
//   high; last marks the final character of the word's text. A '-' leads the
//   text of a negative word. The receiver cannot stall the block.
//   The alphabet (radix, digits_low, digits_high) is written over the APB
//   port at byte addresses 0, 8 and 16; the user must write it only while
//   the block is idle, which the block itself does not enforce. Under an
//   invalid alphabet words are taken and produce no characters. The
//   byte-wide divider finds each of a word's n digits a byte at a time;
//   once all are stacked the characters follow at one character per cycle
//   (n, plus one for the sign). The divider sets the pace.
//   A two-entry queue sits between the front and the divider, so busy rises
//   only once two words are waiting.
//   Reset clears the registers, the queue and the sequencer; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top import srde_pkg::*; #(
	parameter int MAX_RADIX = MAX_RADIX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	output logic               strobe,
	output logic [SYM_W-1:0]   symbol,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t  cfg;
	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	// configuration registers
	srde_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// word intake and classification
	srde_front #(.MAX_RADIX(MAX_RADIX)) u_front (
		.start     (start),
		.value     (value),
		.cfg       (cfg),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_item (push_item)
	);

	// queue between front and back
	srde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	// conversion and character output
	srde_back #(.MAX_RADIX(MAX_RADIX)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.strobe  (strobe),
		.symbol  (symbol),
		.last    (last)
	);

endmodule

// ===== tb/sv/signed_radix_digit_emitter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top_tb
// Sends signed words to the emitter under many digit alphabets, valid and
// broken, and checks every character it writes against a behavioural
// predictor of the conversion, with random gaps on the sending side.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top_tb;
	import srde_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DUT_MAX_RADIX  = MAX_RADIX_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int MAX_REPORTS    = 10;
	localparam int WORDS_PER_SET  = 25;
	localparam int WORDS_PER_PHASE = 125;

	// one character of the written text
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} char_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               strobe;
	logic [SYM_W-1:0]   symbol;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cfg_t  shadow_cfg;
	char_t expected_chars[$];
	int    mismatches      = 0;
	int    sender_idle_pct = 0;
	int    quiet_cycles    = 0;

	signed_radix_digit_emitter_top #(
		.MAX_RADIX(DUT_MAX_RADIX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.symbol(symbol),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// alphabet symbol standing for digit k
	function automatic logic [SYM_W-1:0] alphabet_symbol(input int k);
		if (k < SYM_SLOTS) return shadow_cfg.digits_low[k*SYM_W +: SYM_W];
		return shadow_cfg.digits_high[(k-SYM_SLOTS)*SYM_W +: SYM_W];
	endfunction

	// radix in range, printable symbols other than the signs, no repeats
	function automatic bit alphabet_valid();
		int n;
		logic [SYM_W-1:0] s;
		n = int'(shadow_cfg.radix);
		if (n < 2 || n > DUT_MAX_RADIX) return 1'b0;
		for (int i = 0; i < n; i++) begin
			s = alphabet_symbol(i);
			if (s < SYM_LOWEST || s > SYM_HIGHEST || s == SYM_PLUS || s == SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (alphabet_symbol(j) == s) return 1'b0;
		end
		return 1'b1;
	endfunction

	// queue up the characters one word should produce
	function automatic void spell_value(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		int    base;
		int    count;
		int    rev [TEXT_MAX];
		char_t c;
		if (!alphabet_valid()) return;
		base  = int'(shadow_cfg.radix);
		mag   = v[VALUE_W-1] ? (~v + 1'b1) : v;
		count = 0;
		do begin
			rev[count] = mag % base;
			mag = mag / base;
			count++;
		end while (mag != 0 && count < TEXT_MAX);
		if (v[VALUE_W-1]) begin
			c.symbol = SYM_MINUS;
			c.last   = 1'b0;
			expected_chars.push_back(c);
		end
		while (count > 0) begin
			count--;
			c.symbol = alphabet_symbol(rev[count]);
			c.last   = (count == 0);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
	endfunction

	// one word, after a random number of idle cycles
	task automatic send_word(input logic [VALUE_W-1:0] v);
		bit waiting;
		waiting = 1'b1;
		while (waiting) begin
			@(negedge clk);
			if ($urandom_range(99) < sender_idle_pct) start <= 1'b0;
			else waiting = 1'b0;
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		spell_value(v);
	endtask

	// stop sending and let every pending word drain out
	task automatic settle_block();
		@(negedge clk);
		start <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write, setup then access
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_RADIX: begin
				shadow_cfg.radix = data[RADIX_W-1:0];
			end
			REG_DIGITS_LOW: begin
				shadow_cfg.digits_low = data;
			end
			REG_DIGITS_HIGH: begin
				shadow_cfg.digits_high = data;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// whole alphabet, junk in the unused upper bits of the radix register
	task automatic set_alphabet(input logic [RADIX_W-1:0] r, input logic [PDATA_W-1:0] lo,
			input logic [PDATA_W-1:0] hi);
		logic [PDATA_W-1:0] radix_data;
		radix_data = {$urandom, $urandom};
		radix_data[RADIX_W-1:0] = r;
		settle_block();
		write_reg(REG_RADIX, radix_data);
		write_reg(REG_DIGITS_LOW, lo);
		write_reg(REG_DIGITS_HIGH, hi);
	endtask

	task automatic load_alphabet(input string s);
		logic [PDATA_W-1:0] lo;
		logic [PDATA_W-1:0] hi;
		lo = '0;
		hi = '0;
		for (int k = 0; k < s.len(); k++) begin
			if (k < SYM_SLOTS) lo[k*SYM_W +: SYM_W] = s[k];
			else hi[(k-SYM_SLOTS)*SYM_W +: SYM_W] = s[k];
		end
		set_alphabet(RADIX_W'(s.len()), lo, hi);
	endtask

	// random distinct symbols, optionally broken in one way
	task automatic load_random_alphabet(input int r, input bit corrupt);
		logic [SYM_W-1:0]   syms [2*SYM_SLOTS];
		logic [PDATA_W-1:0] lo;
		logic [PDATA_W-1:0] hi;
		logic [RADIX_W-1:0] r5;
		bit                 used [256];
		logic [SYM_W-1:0]   s;
		int                 k;
		for (k = 0; k < 2*SYM_SLOTS; k++) syms[k] = SYM_W'($urandom);
		for (k = 0; k < r; k++) begin
			do s = SYM_W'($urandom_range(SYM_LOWEST, SYM_HIGHEST));
			while (used[s] || s == SYM_PLUS || s == SYM_MINUS);
			used[s] = 1'b1;
			syms[k] = s;
		end
		r5 = RADIX_W'(r);
		if (corrupt) begin
			k = $urandom_range(0, r - 1);
			case ($urandom_range(3))
				0: begin
					r5 = RADIX_W'($urandom_range(0, 1));
				end
				1: begin
					r5 = RADIX_W'($urandom_range(DUT_MAX_RADIX + 1, 31));
				end
				2: begin
					syms[k] = syms[(k + 1) % r];
				end
				default: begin
					case ($urandom_range(3))
						0: syms[k] = SYM_W'($urandom_range(0, SYM_LOWEST - 1));
						1: syms[k] = SYM_W'($urandom_range(SYM_HIGHEST + 1, 255));
						2: syms[k] = SYM_PLUS;
						default: syms[k] = SYM_MINUS;
					endcase
				end
			endcase
		end
		for (k = 0; k < SYM_SLOTS; k++) begin
			lo[k*SYM_W +: SYM_W] = syms[k];
			hi[k*SYM_W +: SYM_W] = syms[k + SYM_SLOTS];
		end
		set_alphabet(r5, lo, hi);
	endtask

	// mix of extremes, small magnitudes, radix powers and wide random words
	function automatic logic [VALUE_W-1:0] random_value(input int r);
		longint p;
		int     e;
		logic [VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: v = $urandom;
			1: v = $urandom_range(0, 64);
			2: v = -$urandom_range(1, 64);
			3: begin
				case ($urandom_range(2))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					default: v = 32'hffff_ffff;
				endcase
			end
			4: begin
				p = 1;
				e = $urandom_range(0, 31);
				repeat (e) if (p * r < 64'sh8000_0000) p = p * r;
				v = VALUE_W'(p - $urandom_range(0, 1));
				if ($urandom_range(1)) v = -v;
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// registers come out of reset as an empty alphabet
	task automatic test_reset_state();
		send_word(32'd0);
		send_word(32'hffff_ffff);
	endtask

	// decimal, including both ends of the range and a spare register write
	task automatic test_decimal();
		load_alphabet("0123456789");
		settle_block();
		write_reg(REG_UNUSED, '1);
		send_word(32'd0);
		send_word(32'd1);
		send_word(32'hffff_ffff);
		send_word(32'd10);
		send_word(32'h7fff_ffff);
		send_word(32'h8000_0000);
	endtask

	// base two gives the longest texts
	task automatic test_binary();
		load_alphabet("01");
		send_word(32'h8000_0000);
		send_word(32'h7fff_ffff);
		send_word(32'hffff_ffff);
	endtask

	// largest radix, lowest and highest printable symbols
	task automatic test_symbol_extremes();
		load_alphabet("!0123456789abcd~");
		send_word(32'hfedc_ba98);
		send_word(32'h7fff_ffff);
		send_word(32'd0);
	endtask

	// each way of breaking the alphabet must silence the output
	task automatic test_invalid_alphabets();
		load_alphabet("0");
		send_word(32'd12345);
		load_alphabet("0123456789ABCDEF");
		settle_block();
		write_reg(REG_RADIX, 64'd17);
		send_word(-32'sd77);
		settle_block();
		write_reg(REG_RADIX, 64'd31);
		send_word(32'd99);
		load_alphabet("0 1");
		send_word(32'd5);
		load_alphabet("01\177");
		send_word(32'd5);
		load_alphabet("0\3771");
		send_word(32'd5);
		load_alphabet("0+1");
		send_word(-32'sd5);
		load_alphabet("0-1");
		send_word(-32'sd5);
		load_alphabet("0123456789ABCDE0");
		send_word(32'd1000);
	endtask

	// bytes past the radix hold junk that must be ignored
	task automatic test_beyond_radix();
		set_alphabet(5'd3, 64'h7f00_2d2b_3032_3130, 64'h0);
		send_word(-32'sd13);
		send_word(32'h7fff_ffff);
	endtask

	// random alphabets and words, one phase per sender idle rate
	task automatic test_random_traffic();
		int pct [3];
		int accepted;
		int turn;
		int r;
		bit corrupt;
		pct = '{0, 83, 27};
		foreach (pct[ph]) begin
			sender_idle_pct = pct[ph];
			accepted = 0;
			turn = 0;
			while (accepted < WORDS_PER_PHASE) begin
				if (turn % 6 == 0) r = 2;
				else if (turn % 6 == 1) r = DUT_MAX_RADIX;
				else r = $urandom_range(3, DUT_MAX_RADIX - 1);
				corrupt = (turn % 6 >= 2) && ($urandom_range(7) == 0);
				load_random_alphabet(r, corrupt);
				repeat (WORDS_PER_SET) send_word(random_value(r));
				if (alphabet_valid()) accepted += WORDS_PER_SET;
				turn++;
			end
		end
		sender_idle_pct = 0;
	endtask

	// compare each character with the oldest expectation
	always @(posedge clk) begin : check_chars
		char_t want;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				note_failure($sformatf("unexpected character %h last %b", symbol, last));
			end else begin
				want = expected_chars.pop_front();
				if (symbol !== want.symbol)
					note_failure($sformatf("symbol expected %h actual %h",
						want.symbol, symbol));
				if (last !== want.last)
					note_failure($sformatf("last expected %b actual %b (symbol %h)",
						want.last, last, symbol));
			end
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (psel && penable)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// sequence of tests
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		value      = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		shadow_cfg = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_decimal();
		test_binary();
		test_symbol_extremes();
		test_invalid_alphabets();
		test_beyond_radix();
		test_random_traffic();
		settle_block();

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
